>>> sv/pidstm_pkg.sv
// ----------------------------------------------------------------------------
// pidstm_pkg
// Shared types, register map and saturating Q16.16 arithmetic for the
// three-mode PID step block.
// ----------------------------------------------------------------------------
package pidstm_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SUM_W      = DATA_WIDTH + 4;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int PDATA_W    = 32;
    localparam int ADDR_W     = 5;
    localparam int REG_W      = 3;
    localparam int MODE_W     = 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic signed [PROD_W-1:0]     t_prod;

    localparam t_data DATA_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data DATA_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_prod FRAC_MASK = {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_POS  = 2'd0,
        MODE_INC  = 2'd1,
        MODE_COND = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [REG_W-1:0] {
        REG_MODE    = 3'd0,
        REG_GAIN_P  = 3'd1,
        REG_GAIN_I  = 3'd2,
        REG_GAIN_D  = 3'd3,
        REG_GAIN_FF = 3'd4,
        REG_OUT_LO  = 3'd5,
        REG_OUT_HI  = 3'd6,
        REG_I_LIMIT = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_mode mode;
        t_data gain_p;
        t_data gain_i;
        t_data gain_d;
        t_data gain_ff;
        t_data out_low;
        t_data out_high;
        t_data integral_limit;
    } t_cfg;

    typedef struct packed {
        t_data value;
        logic  hit;
    } t_sat;

    // Saturate a widened sum back to the data width, flag when clipped.
    function automatic t_sat sat_sum(input t_sum v);
        t_sat r;
        if (v > t_sum'(DATA_MAX)) begin
            r.value = DATA_MAX;
            r.hit   = 1'b1;
        end else if (v < t_sum'(DATA_MIN)) begin
            r.value = DATA_MIN;
            r.hit   = 1'b1;
        end else begin
            r.value = v[DATA_WIDTH-1:0];
            r.hit   = 1'b0;
        end
        return r;
    endfunction

    // Q-format product: exact product, shift toward zero, saturate.
    function automatic t_sat qmul(input t_data a, input t_data b);
        t_prod p;
        t_prod q;
        t_sat  r;
        p = t_prod'(a) * t_prod'(b);
        q = (p + (p[PROD_W-1] ? FRAC_MASK : t_prod'(0))) >>> FRAC_BITS;
        if (q > t_prod'(DATA_MAX)) begin
            r.value = DATA_MAX;
            r.hit   = 1'b1;
        end else if (q < t_prod'(DATA_MIN)) begin
            r.value = DATA_MIN;
            r.hit   = 1'b1;
        end else begin
            r.value = q[DATA_WIDTH-1:0];
            r.hit   = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> sv/pidstm_regs.sv
// ----------------------------------------------------------------------------
// pidstm_regs
// APB-style configuration registers; any write pulses a state clear.
// ----------------------------------------------------------------------------
module pidstm_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pidstm_pkg::ADDR_W-1:0]  paddr,
    input  logic [pidstm_pkg::PDATA_W-1:0] pwdata,
    output logic [pidstm_pkg::PDATA_W-1:0] prdata,
    output logic                           pready,
    output pidstm_pkg::t_cfg               o_cfg,
    output logic                           o_clear
);
    import pidstm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:ADDR_W-REG_W]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;
    assign o_clear = wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_POS;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.gain_ff        <= '0;
            r_cfg.out_low        <= DATA_MIN;
            r_cfg.out_high       <= DATA_MAX;
            r_cfg.integral_limit <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:    r_cfg.mode           <= t_mode'(pwdata[MODE_W-1:0]);
                REG_GAIN_P:  r_cfg.gain_p         <= pwdata[DATA_WIDTH-1:0];
                REG_GAIN_I:  r_cfg.gain_i         <= pwdata[DATA_WIDTH-1:0];
                REG_GAIN_D:  r_cfg.gain_d         <= pwdata[DATA_WIDTH-1:0];
                REG_GAIN_FF: r_cfg.gain_ff        <= pwdata[DATA_WIDTH-1:0];
                REG_OUT_LO:  r_cfg.out_low        <= pwdata[DATA_WIDTH-1:0];
                REG_OUT_HI:  r_cfg.out_high       <= pwdata[DATA_WIDTH-1:0];
                REG_I_LIMIT: r_cfg.integral_limit <= pwdata[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:    prdata = {{(PDATA_W-MODE_W){1'b0}}, r_cfg.mode};
            REG_GAIN_P:  prdata = r_cfg.gain_p;
            REG_GAIN_I:  prdata = r_cfg.gain_i;
            REG_GAIN_D:  prdata = r_cfg.gain_d;
            REG_GAIN_FF: prdata = r_cfg.gain_ff;
            REG_OUT_LO:  prdata = r_cfg.out_low;
            REG_OUT_HI:  prdata = r_cfg.out_high;
            REG_I_LIMIT: prdata = r_cfg.integral_limit;
            default:     prdata = '0;
        endcase
    end

endmodule

>>> sv/pidstm_core.sv
// ----------------------------------------------------------------------------
// pidstm_core
// Controller state and the single-pass step: error history, integral,
// output accumulator and last target, updated once per fired item.
// ----------------------------------------------------------------------------
module pidstm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pidstm_pkg::t_cfg  i_cfg,
    input  logic              i_clear,
    input  logic              i_fire,
    input  pidstm_pkg::t_data i_setpoint,
    input  pidstm_pkg::t_data i_measured,
    output pidstm_pkg::t_data o_drive,
    output logic              o_limited
);
    import pidstm_pkg::*;

    t_data r_error_prev, r_error_prev2, r_integral, r_output_acc, r_setpoint_prev;
    t_data n_error_prev, n_error_prev2, n_integral, n_output_acc, n_setpoint_prev;

    t_sat  s_err, s_d1, s_d2, s_dsp;
    t_sat  s_mp, s_mi, s_md, s_mf;
    t_sat  s_integ_acc, s_out_pos, s_out_inc, s_trial, s_out_cond;
    t_data err, mp_opnd, md_opnd;
    t_data integ_bound, cond_integ, out_hi_clamped, out_clamped;
    logic  lim_on, hold_integ, clamp_hi, clamp_lo;

    assign s_err = sat_sum(t_sum'(i_setpoint) - t_sum'(i_measured));
    assign err   = s_err.value;
    assign s_d1  = sat_sum(t_sum'(err) - t_sum'(r_error_prev));
    assign s_d2  = sat_sum(t_sum'(err) - t_sum'(r_error_prev) - t_sum'(r_error_prev)
                           + t_sum'(r_error_prev2));
    assign s_dsp = sat_sum(t_sum'(i_setpoint) - t_sum'(r_setpoint_prev));

    // Four shared multipliers; incremental mode swaps in the differences.
    assign mp_opnd = (i_cfg.mode == MODE_INC) ? s_d1.value : err;
    assign md_opnd = (i_cfg.mode == MODE_INC) ? s_d2.value : s_d1.value;
    assign s_mp    = qmul(i_cfg.gain_p, mp_opnd);
    assign s_mi    = qmul(i_cfg.gain_i, err);
    assign s_md    = qmul(i_cfg.gain_d, md_opnd);
    assign s_mf    = qmul(i_cfg.gain_ff, s_dsp.value);

    assign s_integ_acc = sat_sum(t_sum'(r_integral) + t_sum'(s_mi.value));
    assign s_out_pos   = sat_sum(t_sum'(s_mp.value) + t_sum'(s_integ_acc.value)
                                 + t_sum'(s_md.value));
    assign s_out_inc   = sat_sum(t_sum'(r_output_acc) + t_sum'(s_mp.value)
                                 + t_sum'(s_mi.value) + t_sum'(s_md.value)
                                 + t_sum'(s_mf.value));

    // Conditional integration: skip when the trial output already sits
    // at the rail the error pushes toward.
    assign lim_on     = i_cfg.integral_limit > t_data'(0);
    assign s_trial    = sat_sum(t_sum'(s_mp.value) + t_sum'(r_integral)
                                + t_sum'(s_md.value));
    assign hold_integ = ((s_trial.value >= i_cfg.out_high) && (err > t_data'(0)))
                     || ((s_trial.value <= i_cfg.out_low) && (err < t_data'(0)));

    always_comb begin
        if (s_integ_acc.value > i_cfg.integral_limit) begin
            integ_bound = i_cfg.integral_limit;
        end else if (s_integ_acc.value < -i_cfg.integral_limit) begin
            integ_bound = -i_cfg.integral_limit;
        end else begin
            integ_bound = s_integ_acc.value;
        end
    end

    assign cond_integ     = !lim_on ? t_data'(0) : (hold_integ ? r_integral : integ_bound);
    assign s_out_cond     = sat_sum(t_sum'(s_mp.value) + t_sum'(cond_integ)
                                    + t_sum'(s_md.value));
    // High clamp first, low clamp second: an inverted window ends at out_low.
    assign clamp_hi       = s_out_cond.value > i_cfg.out_high;
    assign out_hi_clamped = clamp_hi ? i_cfg.out_high : s_out_cond.value;
    assign clamp_lo       = out_hi_clamped < i_cfg.out_low;
    assign out_clamped    = clamp_lo ? i_cfg.out_low : out_hi_clamped;

    always_comb begin
        n_error_prev    = err;
        n_error_prev2   = r_error_prev;
        n_integral      = r_integral;
        n_output_acc    = r_output_acc;
        n_setpoint_prev = r_setpoint_prev;
        o_limited       = s_err.hit;
        unique case (i_cfg.mode)
            MODE_POS: begin
                n_integral   = s_integ_acc.value;
                n_output_acc = s_out_pos.value;
                o_limited    = s_err.hit | s_mp.hit | s_mi.hit | s_integ_acc.hit
                             | s_d1.hit | s_md.hit | s_out_pos.hit;
            end
            MODE_INC: begin
                n_integral      = s_mi.value;
                n_setpoint_prev = i_setpoint;
                n_output_acc    = s_out_inc.value;
                o_limited       = s_err.hit | s_d1.hit | s_mp.hit | s_mi.hit | s_d2.hit
                                | s_md.hit | s_dsp.hit | s_mf.hit | s_out_inc.hit;
            end
            MODE_COND: begin
                n_integral   = cond_integ;
                n_output_acc = out_clamped;
                o_limited    = s_err.hit | s_mp.hit | s_d1.hit | s_md.hit
                             | (lim_on & (s_trial.hit
                                          | (!hold_integ & (s_mi.hit | s_integ_acc.hit))))
                             | s_out_cond.hit | clamp_hi | clamp_lo;
            end
            default: ;
        endcase
    end

    assign o_drive = n_output_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_error_prev    <= '0;
            r_error_prev2   <= '0;
            r_integral      <= '0;
            r_output_acc    <= '0;
            r_setpoint_prev <= '0;
        end else if (i_fire) begin
            r_error_prev    <= n_error_prev;
            r_error_prev2   <= n_error_prev2;
            r_integral      <= n_integral;
            r_output_acc    <= n_output_acc;
            r_setpoint_prev <= n_setpoint_prev;
        end
    end

`ifndef SYNTHESIS
    a_clear_zeroes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_integral == '0) && (r_output_acc == '0) && (r_error_prev == '0)
                    && (r_error_prev2 == '0) && (r_setpoint_prev == '0))
        else $error("state not cleared after configuration write");

    a_no_limit_no_integral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_clear && (i_cfg.mode == MODE_COND)
         && (i_cfg.integral_limit <= t_data'(0))) |=> (r_integral == '0))
        else $error("integral kept with disabled limit");

    a_integral_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_clear && (i_cfg.mode == MODE_COND)
         && (i_cfg.integral_limit > t_data'(0)))
        |=> (r_integral <= $past(i_cfg.integral_limit))
            && (r_integral >= -$past(i_cfg.integral_limit)))
        else $error("integral outside its bound");

    a_history_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_clear) |=> (r_error_prev2 == $past(r_error_prev)))
        else $error("error history did not shift");
`endif

endmodule

>>> sv/pid_step_three_mode.sv
// ----------------------------------------------------------------------------
// pid_step_three_mode
// Three-mode Q16.16 PID step (positional, incremental with feed-forward,
// positional with conditional integration) behind an APB register port.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_setpoint, i_measured
//   result   out        o_out_valid / i_out_stall o_drive, o_limited
//   config   in/out     psel/penable/pready       paddr, pwdata, prdata
//
// One item per cycle unless the result stalls. Items enter the input register,
// then the multiply-add pass and controller state land in the result register.
// Controller state updates in the same cycle the result register loads.
// Synchronous active-low reset clears control, configuration and state.
// A stalled result holds the pass; the input register still takes an item
// when it is empty.
// ----------------------------------------------------------------------------
module pid_step_three_mode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [31:0]             i_setpoint,
    input  logic signed [31:0]             i_measured,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [31:0]             o_drive,
    output logic                           o_limited,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pidstm_pkg::ADDR_W-1:0]  paddr,
    input  logic [pidstm_pkg::PDATA_W-1:0] pwdata,
    output logic [pidstm_pkg::PDATA_W-1:0] prdata,
    output logic                           pready
);
    import pidstm_pkg::*;

    t_cfg  cfg;
    logic  cfg_clear;
    logic  r_s1_valid;
    t_data r_setpoint, r_measured;
    logic  r_out_valid;
    t_data r_drive;
    logic  r_limited;
    t_data core_drive;
    logic  core_limited;
    logic  advance, in_take;

    pidstm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_clear (cfg_clear)
    );

    pidstm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_clear    (cfg_clear),
        .i_fire     (advance),
        .i_setpoint (r_setpoint),
        .i_measured (r_measured),
        .o_drive    (core_drive),
        .o_limited  (core_limited)
    );

    // Advance when the result register is empty or being drained.
    assign advance     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_limited   = r_limited;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_setpoint <= i_setpoint;
            r_measured <= i_measured;
        end
        if (advance) begin
            r_drive   <= core_drive;
            r_limited <= core_limited;
        end
    end

`ifndef SYNTHESIS
    a_reset_empties_pipe: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_valid && !r_out_valid)
        else $error("pipeline valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_advance_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced item lost");

    a_take_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted item lost");
`endif

endmodule
